/* sv/npc_pkg.sv */
`default_nettype none
package npc_pkg;

  localparam int PALETTE_SIZE_DEF = 256;
  localparam int CHAN_W           = 8;
  localparam int IDX_W            = 8;
  localparam int COLOR_W          = 3 * CHAN_W;
  localparam int SQ_W             = 2 * CHAN_W;
  // 3 * 255^2 = 195075 fits in 18 bits
  localparam int DIST_W           = SQ_W + 2;

  // tag that travels with one palette read through the search pipeline
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
  } scan_tag_t;

endpackage
`default_nettype wire

/* sv/npc_palette_mem.sv */
`default_nettype none
module npc_palette_mem #(
  parameter int Depth = npc_pkg::PALETTE_SIZE_DEF,
  parameter int AddrW = $clog2(npc_pkg::PALETTE_SIZE_DEF)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        wr_en_i,
  input  wire logic [AddrW-1:0]            wr_addr_i,
  input  wire logic [npc_pkg::COLOR_W-1:0] wr_data_i,
  input  wire logic                        rd_en_i,
  input  wire logic [AddrW-1:0]            rd_addr_i,
  output logic      [npc_pkg::COLOR_W-1:0] rd_data_o
);

  logic [npc_pkg::COLOR_W-1:0] mem [Depth];
  logic [npc_pkg::COLOR_W-1:0] mem_rd_q;
  logic [Depth-1:0]            vld_q;
  logic                        vld_rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      mem_rd_q <= mem[rd_addr_i];
    end
  end

  // per-entry written flags; unwritten entries read as black
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        vld_rd_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = vld_rd_q ? mem_rd_q : '0;

endmodule
`default_nettype wire

/* sv/npc_search.sv */
`default_nettype none
module npc_search (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [npc_pkg::CHAN_W-1:0]  red_i,
  input  wire logic [npc_pkg::CHAN_W-1:0]  green_i,
  input  wire logic [npc_pkg::CHAN_W-1:0]  blue_i,
  input  wire npc_pkg::scan_tag_t          tag_i,
  input  wire logic [npc_pkg::COLOR_W-1:0] entry_i,
  output logic                             busy_o,
  output logic      [npc_pkg::IDX_W-1:0]   best_idx_o
);

  localparam int CW = npc_pkg::CHAN_W;
  localparam int SW = npc_pkg::SQ_W;
  localparam int DW = npc_pkg::DIST_W;

  function automatic logic [SW-1:0] chan_sq(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SW'(d) * SW'(d);
  endfunction

  npc_pkg::scan_tag_t    sq_tag_q;
  logic [SW-1:0]         sq_r_q, sq_g_q, sq_b_q;
  logic [DW-1:0]         cur_dist;
  logic [DW-1:0]         best_dist_q;
  logic [npc_pkg::IDX_W-1:0] best_idx_q;
  logic                  first_q;

  // stage 1: per-channel squared differences
  always_ff @(posedge clk_i) begin
    sq_r_q <= chan_sq(red_i,   entry_i[3*CW-1:2*CW]);
    sq_g_q <= chan_sq(green_i, entry_i[2*CW-1:CW]);
    sq_b_q <= chan_sq(blue_i,  entry_i[CW-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_tag_q <= '0;
    end else begin
      sq_tag_q <= tag_i;
    end
  end

  // stage 2: sum and keep the strictly smaller distance (lowest index on ties)
  assign cur_dist = DW'(sq_r_q) + DW'(sq_g_q) + DW'(sq_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else if (start_i) begin
      first_q <= 1'b1;
    end else if (sq_tag_q.vld) begin
      first_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_tag_q.vld && (first_q || (cur_dist < best_dist_q))) begin
      best_dist_q <= cur_dist;
      best_idx_q  <= sq_tag_q.idx;
    end
  end

  assign busy_o     = sq_tag_q.vld;
  assign best_idx_o = best_idx_q;

endmodule
`default_nettype wire

/* sv/nearest_palette_color_unit.sv */
`default_nettype none
// Nearest palette color unit. Holds a palette of PALETTE_SIZE 24-bit RGB
// entries, all black after reset. An input transaction with cmd_i = 0 writes
// {red, green, blue} to entry entry_index_i (ignored if the index is beyond
// the palette) and produces no output. A transaction with cmd_i = 1 returns
// the index of the entry in 1..PALETTE_SIZE-1 with the smallest squared RGB
// distance to the query color, lowest index on ties; entry 0 is never a
// candidate. With trans_enable set (config channel), a pure black query
// returns 0 without a search. A search query reads entries 1..PALETTE_SIZE-1,
// one entry per cycle from the single read port of the palette memory, then
// drains the search pipeline and hands the result to the output register.
// One transaction is worked on at a time; a finished result sits in the
// output register so loads can proceed while it waits.
module nearest_palette_color_unit #(
  parameter int PALETTE_SIZE = npc_pkg::PALETTE_SIZE_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // config write channel
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic                            trans_enable_i,
  // input transactions
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            cmd_i,
  input  wire logic [npc_pkg::IDX_W-1:0]       entry_index_i,
  input  wire logic [npc_pkg::CHAN_W-1:0]      red_i,
  input  wire logic [npc_pkg::CHAN_W-1:0]      green_i,
  input  wire logic [npc_pkg::CHAN_W-1:0]      blue_i,
  // results
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [npc_pkg::IDX_W-1:0]       palette_index_o
);

  localparam int AW = $clog2(PALETTE_SIZE);
  localparam int IW = npc_pkg::IDX_W;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_RESULT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic                        trans_en_q;
  logic                        in_fire, load_fire, query_fire, black_hit;
  logic                        wr_en;
  logic [IW-1:0]               cnt_q, cnt_d;
  logic                        trans_hit_q, trans_hit_d;
  logic [npc_pkg::CHAN_W-1:0]  qr_q, qg_q, qb_q;
  npc_pkg::scan_tag_t          rd_tag_q, rd_tag_d;
  logic                        rd_en;
  logic [npc_pkg::COLOR_W-1:0] rd_data;
  logic                        search_busy;
  logic [IW-1:0]               best_idx;
  logic                        out_valid_q, out_valid_d;
  logic [IW-1:0]               out_idx_q, out_idx_d;
  logic                        out_load;

  // config register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trans_en_q <= 1'b0;
    end else if (cfg_valid_i) begin
      trans_en_q <= trans_enable_i;
    end
  end

  // input side
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_fire  = in_fire && (cmd_i == CMD_LOAD);
  assign query_fire = in_fire && (cmd_i == CMD_QUERY);
  assign black_hit  = trans_en_q && (red_i == '0) && (green_i == '0) && (blue_i == '0);
  assign wr_en      = load_fire && ({1'b0, entry_index_i} < (IW + 1)'(PALETTE_SIZE));

  always_ff @(posedge clk_i) begin
    if (query_fire) begin
      qr_q <= red_i;
      qg_q <= green_i;
      qb_q <= blue_i;
    end
  end

  // scan sequencer
  assign rd_en    = (state_q == ST_SCAN);
  assign out_load = (state_q == ST_RESULT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    trans_hit_d    = trans_hit_q;
    rd_tag_d.vld   = rd_en;
    rd_tag_d.idx   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (query_fire) begin
          trans_hit_d = black_hit;
          cnt_d       = IW'(1);
          state_d     = black_hit ? ST_RESULT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + IW'(1);
        if (cnt_q == IW'(PALETTE_SIZE - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_tag_q.vld && !search_busy) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      trans_hit_q <= 1'b0;
      rd_tag_q    <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      trans_hit_q <= trans_hit_d;
      rd_tag_q    <= rd_tag_d;
    end
  end

  // palette memory: writes only while idle, reads only while scanning
  npc_palette_mem #(
    .Depth (PALETTE_SIZE),
    .AddrW (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (entry_index_i[AW-1:0]),
    .wr_data_i ({red_i, green_i, blue_i}),
    .rd_en_i   (rd_en),
    .rd_addr_i (cnt_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  npc_search u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (query_fire),
    .red_i      (qr_q),
    .green_i    (qg_q),
    .blue_i     (qb_q),
    .tag_i      (rd_tag_q),
    .entry_i    (rd_data),
    .busy_o     (search_busy),
    .best_idx_o (best_idx)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_idx_d   = out_idx_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      out_idx_d   = trans_hit_q ? '0 : best_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_idx_q <= out_idx_d;
  end

  assign out_valid_o     = out_valid_q;
  assign palette_index_o = out_idx_q;

endmodule
`default_nettype wire

/* verif/npc_checker.sv */
`timescale 1ns / 100ps

package npc_tb_pkg;
  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } npc_cmd_e;
endpackage

module npc_checker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  input  wire logic                        cfg_ready_i,
  input  wire logic                        trans_enable_i,
  input  wire logic                        in_valid_i,
  input  wire logic                        in_ready_i,
  input  wire logic                        cmd_i,
  input  wire logic [npc_pkg::IDX_W-1:0]   entry_index_i,
  input  wire logic [npc_pkg::CHAN_W-1:0]  red_i,
  input  wire logic [npc_pkg::CHAN_W-1:0]  green_i,
  input  wire logic [npc_pkg::CHAN_W-1:0]  blue_i,
  input  wire logic                        out_valid_i,
  input  wire logic                        out_ready_i,
  input  wire logic [npc_pkg::IDX_W-1:0]   palette_index_i,
  output int                               fail_count_o,
  output int                               pending_o
);
  import npc_pkg::*;
  import npc_tb_pkg::*;

  localparam int unsigned CHAN_MAX     = 255;
  localparam int unsigned START_MARGIN = 100;
  // above any reachable squared distance, so entry 1 always wins first
  localparam logic [DIST_W-1:0] FAR_DIST = DIST_W'(3 * CHAN_MAX * CHAN_MAX + START_MARGIN);

  logic [COLOR_W-1:0] palette_shadow [PALETTE_SIZE_DEF];
  logic               trans_en;
  logic [IDX_W-1:0]   nearest_idx_q [$];
  logic [IDX_W-1:0]   want_idx;
  int                 mismatches;

  function automatic logic [SQ_W-1:0] chan_dist_sq(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a > b) ? a - b : b - a;
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  // exhaustive search over entries 1..top, strict < keeps the lowest index on ties
  function automatic logic [IDX_W-1:0] nearest_entry(input logic [CHAN_W-1:0] r,
                                                     input logic [CHAN_W-1:0] g,
                                                     input logic [CHAN_W-1:0] b);
    logic [DIST_W-1:0]  best_d;
    logic [DIST_W-1:0]  d;
    logic [IDX_W-1:0]   best_i;
    logic [COLOR_W-1:0] e;
    best_d = FAR_DIST;
    best_i = IDX_W'(1);
    for (int i = 1; i < PALETTE_SIZE_DEF; i++) begin
      e = palette_shadow[i];
      d = DIST_W'(chan_dist_sq(r, e[2*CHAN_W +: CHAN_W]))
        + DIST_W'(chan_dist_sq(g, e[CHAN_W +: CHAN_W]))
        + DIST_W'(chan_dist_sq(b, e[0 +: CHAN_W]));
      if (d < best_d) begin
        best_d = d;
        best_i = IDX_W'(i);
      end
    end
    return best_i;
  endfunction

  task automatic log_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s", $realtime, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PALETTE_SIZE_DEF; i++)
        palette_shadow[i] = '0;
      trans_en = 1'b0;
      nearest_idx_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i)
        trans_en = trans_enable_i;

      if (in_valid_i && in_ready_i) begin
        if (cmd_i == CMD_LOAD) begin
          if (int'(entry_index_i) < PALETTE_SIZE_DEF)
            palette_shadow[entry_index_i] = {red_i, green_i, blue_i};
        end else if (trans_en && {red_i, green_i, blue_i} == '0) begin
          nearest_idx_q.push_back('0);
        end else begin
          nearest_idx_q.push_back(nearest_entry(red_i, green_i, blue_i));
        end
      end

      if (out_valid_i && out_ready_i) begin
        if (nearest_idx_q.size() == 0) begin
          log_mismatch($sformatf("palette_index: expected none, got %0d", palette_index_i));
        end else begin
          want_idx = nearest_idx_q.pop_front();
          if (palette_index_i !== want_idx)
            log_mismatch($sformatf("palette_index: expected %0d, got %0d",
                                   want_idx, palette_index_i));
        end
      end

      fail_count_o <= mismatches;
      pending_o <= nearest_idx_q.size();
    end
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import npc_pkg::*;
  import npc_tb_pkg::*;

  localparam int CHAN_TOP        = 255;
  // no-transaction cycles before giving up
  localparam int WATCHDOG_LIMIT  = 4000;
  // a load that gives no result may still be in flight when pending hits zero
  localparam int LOAD_SETTLE     = 8;
  // final quiet period, about one full search
  localparam int DRAIN_CYCLES    = 300;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 305;
  localparam int COLOR_LOG_DEPTH = 64;

  logic                clk;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                trans_enable;
  logic                in_valid;
  logic                in_ready;
  npc_cmd_e            cmd;
  logic [IDX_W-1:0]    entry_index;
  logic [CHAN_W-1:0]   red;
  logic [CHAN_W-1:0]   green;
  logic [CHAN_W-1:0]   blue;
  logic                out_valid;
  logic                out_ready;
  logic [IDX_W-1:0]    palette_index;

  int                  fail_count;
  int                  pending;
  int unsigned         idle_cycles = 0;
  // when set, neither side inserts gaps
  bit                  calm = 1'b0;
  // recently loaded colors, used to aim queries at real entries and to make ties
  logic [COLOR_W-1:0]  color_log [$];

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  nearest_palette_color_unit uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .trans_enable_i  (trans_enable),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .cmd_i           (cmd),
    .entry_index_i   (entry_index),
    .red_i           (red),
    .green_i         (green),
    .blue_i          (blue),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .palette_index_o (palette_index)
  );

  npc_checker result_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .trans_enable_i  (trans_enable),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .cmd_i           (cmd),
    .entry_index_i   (entry_index),
    .red_i           (red),
    .green_i         (green),
    .blue_i          (blue),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .palette_index_i (palette_index),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Channel value biased toward the extremes.
  function automatic logic [CHAN_W-1:0] rand_chan();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return CHAN_W'(CHAN_TOP);
    return CHAN_W'($urandom);
  endfunction

  // Load target: edges (entry 0, first candidate, last entry) get extra weight.
  function automatic logic [IDX_W-1:0] rand_entry();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5)  return '0;
    if (r < 10) return IDX_W'(1);
    if (r < 15) return IDX_W'(PALETTE_SIZE_DEF - 1);
    return IDX_W'($urandom);
  endfunction

  // Small saturating offset, so the query lands near an entry, usually not on it.
  function automatic logic [CHAN_W-1:0] nudge(input logic [CHAN_W-1:0] v);
    int s;
    s = int'(v) + int'($urandom_range(0, 6)) - 3;
    if (s < 0) s = 0;
    if (s > CHAN_TOP) s = CHAN_TOP;
    return CHAN_W'(s);
  endfunction

  // One input transaction. Valid rises at a falling edge, holds until the
  // rising edge that sees ready, then either stays up for back-to-back
  // traffic or drops for a random gap.
  task automatic send_item(input npc_cmd_e op, input logic [IDX_W-1:0] idx,
                           input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                           input logic [CHAN_W-1:0] b);
    int unsigned gap;
    @(negedge clk);
    in_valid    <= 1'b1;
    cmd         <= op;
    entry_index <= idx;
    red         <= r;
    green       <= g;
    blue        <= b;
    do @(posedge clk); while (!in_ready);
    if (op == CMD_LOAD) begin
      color_log.push_back({r, g, b});
      if (color_log.size() > COLOR_LOG_DEPTH)
        void'(color_log.pop_front());
    end
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Hold the input side until every query has been answered and any
  // trailing load has settled.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LOAD_SETTLE) @(posedge clk);
  endtask

  // Register write, only ever issued with the block idle.
  task automatic write_trans_enable(input logic v);
    wait_idle();
    @(negedge clk);
    cfg_valid    <= 1'b1;
    trans_enable <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic: a bit over half loads, the rest queries. Queries are
  // aimed at logged colors (exact hits and near misses), pure black for the
  // transparency path, or anywhere. Some loads reuse a logged color so that
  // equal-distance ties show up.
  task automatic send_random_item();
    logic [COLOR_W-1:0] c;
    int unsigned        pick;
    pick = $urandom_range(0, 99);
    c = {rand_chan(), rand_chan(), rand_chan()};
    if (pick < 55) begin
      if (color_log.size() > 0 && $urandom_range(0, 99) < 15)
        c = color_log[$urandom_range(0, color_log.size() - 1)];
      send_item(CMD_LOAD, rand_entry(), c[2*CHAN_W +: CHAN_W], c[CHAN_W +: CHAN_W],
                c[0 +: CHAN_W]);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        c = '0;
      end else if (pick < 60 && color_log.size() > 0) begin
        c = color_log[$urandom_range(0, color_log.size() - 1)];
        if (pick >= 35)
          c = {nudge(c[2*CHAN_W +: CHAN_W]), nudge(c[CHAN_W +: CHAN_W]),
               nudge(c[0 +: CHAN_W])};
      end
      send_item(CMD_QUERY, IDX_W'($urandom), c[2*CHAN_W +: CHAN_W], c[CHAN_W +: CHAN_W],
                c[0 +: CHAN_W]);
    end
  endtask

  // Result side: ready bursts broken by random stalls, none in calm stretches.
  initial begin : result_sink
    int unsigned n;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      n = calm ? 50 : $urandom_range(1, 24);
      @(negedge clk);
      out_ready <= 1'b1;
      repeat (n - 1) @(negedge clk);
      n = calm ? 0 : pick_gap();
      if (n > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  // Watchdog: too long without any transaction on any channel means a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    rst_n        <= 1'b0;
    cfg_valid    <= 1'b0;
    trans_enable <= 1'b0;
    in_valid     <= 1'b0;
    cmd          <= CMD_LOAD;
    entry_index  <= '0;
    red          <= '0;
    green        <= '0;
    blue         <= '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed ----
    write_trans_enable(1'b0);
    // all-black palette: every candidate ties, lowest search index wins
    send_item(CMD_QUERY, IDX_W'(0), 0, 0, 0);
    send_item(CMD_QUERY, IDX_W'(255), 255, 255, 255);
    // entry 0 takes the write but never competes
    send_item(CMD_LOAD, IDX_W'(0), 255, 255, 255);
    send_item(CMD_QUERY, IDX_W'(0), 255, 255, 255);
    send_item(CMD_LOAD, IDX_W'(255), 255, 255, 255);
    send_item(CMD_QUERY, IDX_W'(17), 250, 251, 252);
    send_item(CMD_LOAD, IDX_W'(1), 255, 0, 0);
    send_item(CMD_LOAD, IDX_W'(2), 0, 0, 255);
    send_item(CMD_LOAD, IDX_W'(128), 0, 255, 0);
    // same color higher up: the lower index must still win
    send_item(CMD_LOAD, IDX_W'(200), 0, 255, 0);
    send_item(CMD_QUERY, IDX_W'(200), 0, 255, 0);
    send_item(CMD_QUERY, IDX_W'(1), 255, 0, 0);
    // exactly halfway between entries 1 and 2
    send_item(CMD_QUERY, IDX_W'(2), 128, 0, 128);
    // black with transparency off goes through the normal search
    send_item(CMD_QUERY, IDX_W'(0), 0, 0, 0);
    write_trans_enable(1'b1);
    send_item(CMD_QUERY, IDX_W'(255), 0, 0, 0);
    // one LSB off black: searched, not transparent
    send_item(CMD_QUERY, IDX_W'(0), 0, 0, 1);
    send_item(CMD_QUERY, IDX_W'(0), 1, 0, 0);
    send_item(CMD_LOAD, IDX_W'(3), 128, 128, 128);
    send_item(CMD_QUERY, IDX_W'(0), 127, 129, 128);

    // ---- random phases, register changed between them ----
    for (int p = 0; p < PHASES; p++) begin
      calm = (p == 2);
      if (p < 2)
        write_trans_enable(p[0] ? 1'b1 : 1'b0);
      else
        write_trans_enable($urandom_range(0, 1) == 1);
      // seed a handful of entries so queries have something to find
      for (int k = 0; k < 8; k++)
        send_item(CMD_LOAD, IDX_W'($urandom), rand_chan(), rand_chan(), rand_chan());
      for (int k = 8; k < ITEMS_PER_PHASE; k++) begin
        // mid-phase drain: sender holds until all answers are back
        if (p == 3 && k == ITEMS_PER_PHASE / 2)
          wait_idle();
        send_random_item();
      end
    end
    calm = 1'b0;

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
